/* hdl/lcpc_pkg.sv */
// ----------------------------------------------------------------------------
// lcpc_pkg
// shared types, register indexes and pattern tables of the led chaser
// ----------------------------------------------------------------------------
package lcpc_pkg;

    localparam int PWM_PERIOD = 10;
    localparam int PHASE_W    = $clog2(PWM_PERIOD);
    localparam int CMP_W      = 5;

    localparam int LED_W      = 8;
    localparam int DUTY_W     = 4;
    localparam int LIGHT_W    = 8;
    localparam int IVL_W      = 12;
    localparam int MODE_W     = 3;
    localparam int CNT_W      = 16;
    localparam int STEP_W     = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int OUT_TDATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IVL_MODE1 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IVL_MODE2 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IVL_MODE3 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_IVL_MODE4 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PATTERN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_EN   = 3'd5;

    // pattern modes
    localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OUTER  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INNER  = 3'd4;

    // light thresholds
    localparam logic [LIGHT_W-1:0] LIGHT_T1   = 8'd63;
    localparam logic [LIGHT_W-1:0] LIGHT_T2   = 8'd127;
    localparam logic [LIGHT_W-1:0] LIGHT_T3   = 8'd191;
    localparam logic [LIGHT_W-1:0] LIGHT_KEEP = 8'd255;

    localparam logic [IVL_W-1:0]  IVL_RESET   = 12'd400;
    localparam logic [LED_W-1:0]  LED_OFF     = 8'hff;
    localparam logic [LED_W-1:0]  LEFT_RESET  = 8'h01;
    localparam logic [LED_W-1:0]  RIGHT_RESET = 8'h80;
    localparam logic [STEP_W-1:0] STEP_LAST   = 3'd4;

    typedef struct packed {
        logic [3:0][IVL_W-1:0] interval;
        logic [MODE_W-1:0]     mode;
        logic                  step_en;
    } t_cfg;

    function automatic logic [LED_W-1:0] outward_entry(input logic [1:0] idx);
        logic [LED_W-1:0] e;
        case (idx)
            2'd0:    e = 8'h81;
            2'd1:    e = 8'h42;
            2'd2:    e = 8'h24;
            default: e = 8'h18;
        endcase
        return e;
    endfunction

    function automatic logic [LED_W-1:0] inward_entry(input logic [1:0] idx);
        return outward_entry(2'd3 - idx);
    endfunction

endpackage

/* hdl/lcpc_core.sv */
// ----------------------------------------------------------------------------
// lcpc_core
// tick state: interval counter, pwm phase, duty level and pattern registers
// ----------------------------------------------------------------------------
module lcpc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [lcpc_pkg::LIGHT_W-1:0] i_light,
    input  lcpc_pkg::t_cfg               i_cfg,
    output logic [lcpc_pkg::LED_W-1:0]   o_led,
    output logic [lcpc_pkg::DUTY_W-1:0]  o_duty
);
    import lcpc_pkg::*;

    logic [CNT_W-1:0]   r_count,   n_count;
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic [DUTY_W-1:0]  r_duty,    n_duty;
    logic               r_pending, n_pending;
    logic [LED_W-1:0]   r_left,    n_left;
    logic [LED_W-1:0]   r_right,   n_right;
    logic [STEP_W-1:0]  r_step,    n_step;
    logic [LED_W-1:0]   r_drive,   n_drive;

    logic [CNT_W-1:0]   count_inc;
    logic [PHASE_W:0]   phase_inc;
    logic [IVL_W-1:0]   ivl;
    logic [1:0]         ivl_sel;
    logic               mode_ok;
    logic               req;
    logic               gate;
    logic               pend;

    always_comb begin
        mode_ok   = (i_cfg.mode >= MODE_LEFT) && (i_cfg.mode <= MODE_INNER);
        ivl_sel   = 2'(i_cfg.mode - 3'd1);
        ivl       = i_cfg.interval[ivl_sel];
        count_inc = r_count + 16'd1;
        req       = mode_ok && i_cfg.step_en && (count_inc >= CNT_W'(ivl));
        n_count   = req ? '0 : count_inc;
        pend      = r_pending | req;

        phase_inc = (PHASE_W+1)'(r_phase) + (PHASE_W+1)'(1);
        if (phase_inc >= (PHASE_W+1)'(PWM_PERIOD)) begin
            n_phase = '0;
        end else begin
            n_phase = phase_inc[PHASE_W-1:0];
        end
        gate = CMP_W'(n_phase) <= CMP_W'(r_duty);

        if (i_light < LIGHT_T1) begin
            n_duty = 4'd2;
        end else if (i_light < LIGHT_T2) begin
            n_duty = 4'd4;
        end else if (i_light < LIGHT_T3) begin
            n_duty = 4'd6;
        end else if (i_light != LIGHT_KEEP) begin
            n_duty = 4'd8;
        end else begin
            n_duty = r_duty;
        end

        n_pending = pend;
        n_left    = r_left;
        n_right   = r_right;
        n_step    = r_step;
        n_drive   = r_drive;
        if (gate) begin
            unique case (i_cfg.mode) inside
                MODE_LEFT: begin
                    n_drive = ~r_left;
                    if (pend) begin
                        n_left    = {r_left[LED_W-2:0], r_left[LED_W-1]};
                        n_pending = 1'b0;
                    end
                end
                MODE_RIGHT: begin
                    n_drive = ~r_right;
                    if (pend) begin
                        n_right   = {r_right[0], r_right[LED_W-1:1]};
                        n_pending = 1'b0;
                    end
                end
                MODE_OUTER, MODE_INNER: begin
                    if (pend) begin
                        n_pending = 1'b0;
                        n_step    = (r_step >= STEP_LAST) ? 3'd1 : r_step + 3'd1;
                    end
                    if (n_step != '0 && n_step <= STEP_LAST) begin
                        n_drive = (i_cfg.mode == MODE_OUTER)
                                ? ~outward_entry(2'(n_step - 3'd1))
                                : ~inward_entry(2'(n_step - 3'd1));
                    end
                end
                default: begin
                    n_drive = r_drive;
                end
            endcase
        end else begin
            n_drive = LED_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_phase   <= '0;
            r_duty    <= '0;
            r_pending <= 1'b0;
            r_left    <= LEFT_RESET;
            r_right   <= RIGHT_RESET;
            r_step    <= '0;
            r_drive   <= LED_OFF;
        end else if (i_accept) begin
            r_count   <= n_count;
            r_phase   <= n_phase;
            r_duty    <= n_duty;
            r_pending <= n_pending;
            r_left    <= n_left;
            r_right   <= n_right;
            r_step    <= n_step;
            r_drive   <= n_drive;
        end
    end

    assign o_led  = n_drive;
    assign o_duty = n_duty;

endmodule

/* hdl/led_chaser_pwm_controller_top.sv */
// ----------------------------------------------------------------------------
// led_chaser_pwm_controller_top
// led chaser with pwm dimming, one light sample per tick transfer
// ----------------------------------------------------------------------------
// each result is registered in the output register, or in the skid register
// throughput: one item per cycle while the skid register is empty
// a two-entry output stage keeps input ready while one result waits
// reset: synchronous active low, restores registers and tick state
// ----------------------------------------------------------------------------
module led_chaser_pwm_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcpc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [lcpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lcpc_pkg::LIGHT_W-1:0]      s_axis_tdata,   // light_level
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [lcpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // led_drive, duty_level, pad
);
    import lcpc_pkg::*;

    localparam int RES_W = LED_W + DUTY_W;

    t_cfg             r_cfg;
    logic             accept;
    logic             take;
    logic [LED_W-1:0] led;
    logic [DUTY_W-1:0] duty;
    logic [RES_W-1:0] res;

    logic             r_out_valid, n_out_valid;
    logic             r_skid_valid, n_skid_valid;
    logic [RES_W-1:0] r_out, n_out;
    logic [RES_W-1:0] r_skid, n_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval <= {4{IVL_RESET}};
            r_cfg.mode     <= MODE_LEFT;
            r_cfg.step_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr) inside
                CFG_IVL_MODE1, CFG_IVL_MODE2, CFG_IVL_MODE3, CFG_IVL_MODE4: begin
                    r_cfg.interval[i_cfg_addr[1:0]] <= i_cfg_data;
                end
                CFG_PATTERN: begin
                    r_cfg.mode <= i_cfg_data[MODE_W-1:0];
                end
                CFG_STEP_EN: begin
                    r_cfg.step_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;

    lcpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_light  (s_axis_tdata),
        .i_cfg    (r_cfg),
        .o_led    (led),
        .o_duty   (duty)
    );

    assign res = {duty, led};

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid  = 1'b0;
            end
        end
        if (accept) begin
            if (!r_out_valid || take) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

endmodule

/* hdl/lcpc_checker.sv */
// ----------------------------------------------------------------------------
// lcpc_checker
// port-level checks of the led chaser, bound to the top level
// ----------------------------------------------------------------------------
module lcpc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [lcpc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input logic [lcpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [lcpc_pkg::LIGHT_W-1:0]      s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lcpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import lcpc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("input transfer without result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[11:8] <= 4'd8) && (m_axis_tdata[15:12] == 4'd0))
        else $error("duty level out of range");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind led_chaser_pwm_controller_top lcpc_checker u_lcpc_checker (.*);

/* tb/sv/led_chaser_pwm_controller_top_tb.sv */
// ----------------------------------------------------------------------------
// led_chaser_pwm_controller_top_tb
// self-checking bench for the led chaser: light samples go in on the slave
// stream and a tick model predicts led lines and duty level for each one.
// every result transfer is compared field by field against the model. a
// short edge-case sequence comes first, then phases of random samples, each
// under a fresh set of registers, with random idle on both stream sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module led_chaser_pwm_controller_top_tb;
    import lcpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 16;
    localparam int MAX_PRINTS  = 50;

    localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

    localparam logic [3:0][LED_W-1:0] SPREAD_TAB = {8'h18, 8'h24, 8'h42, 8'h81};
    localparam logic [0:11][LIGHT_W-1:0] EDGE_LIGHTS = {
        8'd255, 8'd255, 8'd0, 8'd62, 8'd63, 8'd126,
        8'd127, 8'd190, 8'd191, 8'd254, 8'd255, 8'd128
    };

    typedef struct packed {
        logic [LED_W-1:0]  led;
        logic [DUTY_W-1:0] duty;
    } chaser_out_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [LIGHT_W-1:0]     s_axis_tdata = '0;   // light_level
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // led_drive, duty_level, pad

    // model registers
    logic [IVL_W-1:0]  step_ivl [4];
    logic [MODE_W-1:0] cur_mode;
    logic              step_on;

    // model tick state
    logic [CNT_W-1:0]  tick_cnt;
    logic [3:0]        pwm_ph;
    logic [DUTY_W-1:0] held_duty;
    logic              step_req;
    logic [LED_W-1:0]  left_pat;
    logic [LED_W-1:0]  right_pat;
    logic [STEP_W-1:0] tbl_step;
    logic [LED_W-1:0]  drive;

    logic [LIGHT_W-1:0] light_q [$];
    chaser_out_t        expected_leds_q [$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    logic hold_arm = 1'b0;
    logic sink_hold = 1'b0;

    int err_cnt = 0;
    int checked = 0;
    int fed = 0;
    int steps_taken = 0;
    int cfg_loads = 0;
    int cyc = 0;

    led_chaser_pwm_controller_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void chaser_reset();
        int r;
        for (r = 0; r < 4; r++) step_ivl[r] = IVL_RESET;
        cur_mode  = MODE_LEFT;
        step_on   = 1'b1;
        tick_cnt  = '0;
        pwm_ph    = '0;
        held_duty = '0;
        step_req  = 1'b0;
        left_pat  = LEFT_RESET;
        right_pat = RIGHT_RESET;
        tbl_step  = '0;
        drive     = LED_OFF;
    endfunction

    function automatic void chaser_tick(input logic [LIGHT_W-1:0] light);
        logic mode_ok;
        logic gate;
        logic [LED_W-1:0] entry;
        chaser_out_t res;
        tick_cnt = tick_cnt + 1'b1;
        mode_ok = (cur_mode >= MODE_LEFT) && (cur_mode <= MODE_INNER);
        if (mode_ok && step_on && tick_cnt >= CNT_W'(step_ivl[2'(cur_mode - 1'b1)])) begin
            step_req = 1'b1;
            tick_cnt = '0;
        end
        if (int'(pwm_ph) + 1 >= PWM_PERIOD) pwm_ph = '0;
        else pwm_ph = pwm_ph + 1'b1;
        // gate uses the duty level from before this sample
        gate = (pwm_ph <= held_duty);
        if (light < LIGHT_T1) held_duty = 4'd2;
        else if (light < LIGHT_T2) held_duty = 4'd4;
        else if (light < LIGHT_T3) held_duty = 4'd6;
        else if (light != LIGHT_KEEP) held_duty = 4'd8;
        if (gate) begin
            case (cur_mode) inside
                MODE_LEFT: begin
                    drive = ~left_pat;
                    if (step_req) begin
                        left_pat = {left_pat[LED_W-2:0], left_pat[LED_W-1]};
                        step_req = 1'b0;
                        steps_taken++;
                    end
                end
                MODE_RIGHT: begin
                    drive = ~right_pat;
                    if (step_req) begin
                        right_pat = {right_pat[0], right_pat[LED_W-1:1]};
                        step_req = 1'b0;
                        steps_taken++;
                    end
                end
                MODE_OUTER, MODE_INNER: begin
                    if (step_req) begin
                        step_req = 1'b0;
                        steps_taken++;
                        tbl_step = (tbl_step >= STEP_LAST) ? 3'd1 : tbl_step + 1'b1;
                    end
                    // before the first table step the old drive is kept
                    if (tbl_step != '0) begin
                        entry = (cur_mode == MODE_OUTER) ? SPREAD_TAB[2'(tbl_step - 1'b1)]
                                                         : SPREAD_TAB[2'(STEP_LAST - tbl_step)];
                        drive = ~entry;
                    end
                end
                default: ;
            endcase
        end else begin
            drive = LED_OFF;
        end
        res.led  = drive;
        res.duty = held_duty;
        expected_leds_q.push_back(res);
    endfunction

    function automatic logic [IVL_W-1:0] pick_interval();
        case ($urandom_range(9))
            0: return '0;
            1: return IVL_W'($urandom_range(60, 20));
            default: return IVL_W'($urandom_range(8, 1));
        endcase
    endfunction

    function automatic logic [LIGHT_W-1:0] pick_light();
        logic [LIGHT_W-1:0] thr;
        case ($urandom_range(2))
            0: thr = LIGHT_T1;
            1: thr = LIGHT_T2;
            default: thr = LIGHT_T3;
        endcase
        case ($urandom_range(7))
            0: return LIGHT_KEEP;
            1: return LIGHT_W'(thr - $urandom_range(1));
            default: return LIGHT_W'($urandom_range(255));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
                     what, checked, want, got);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
    endtask

    // writes every register from the model copy, block must be idle
    task automatic load_cfg();
        int r;
        for (r = 0; r < 4; r++) put_reg(CFG_IVL_MODE1 + CFG_ADDR_W'(r), step_ivl[r]);
        put_reg(CFG_PATTERN, CFG_DATA_W'(cur_mode));
        put_reg(CFG_STEP_EN, CFG_DATA_W'(step_on));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_loads++;
        @(negedge i_clk);
    endtask

    task automatic queue_lights(input logic [LIGHT_W-1:0] light, input int n);
        int k;
        for (k = 0; k < n; k++) light_q.push_back(light);
    endtask

    task automatic wait_idle();
        while (light_q.size() != 0 || s_axis_tvalid || expected_leds_q.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                chaser_tick(s_axis_tdata);
                fed++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (light_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tdata  <= light_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        chaser_out_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_leds_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, m_axis_tdata);
                end else begin
                    want = expected_leds_q.pop_front();
                    if (m_axis_tdata[LED_W-1:0] != want.led)
                        report_mismatch("led_drive", want.led, m_axis_tdata[LED_W-1:0]);
                    if (m_axis_tdata[LED_W +: DUTY_W] != want.duty)
                        report_mismatch("duty_level", want.duty, m_axis_tdata[LED_W +: DUTY_W]);
                    if (m_axis_tdata[OUT_TDATA_W-1:LED_W+DUTY_W] != '0)
                        report_mismatch("pad bits", 0, m_axis_tdata[OUT_TDATA_W-1:LED_W+DUTY_W]);
                end
                checked++;
            end
            if (sink_hold) m_axis_tready <= 1'b0;
            else m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_arm);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cyc, expected_leds_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int p, k, n_items;
        chaser_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // duty thresholds and the keep value under reset settings
        for (k = 0; k < 12; k++) light_q.push_back(EDGE_LIGHTS[k]);
        wait_idle();

        // table mode before any step, then an unused mode
        step_on  = 1'b0;
        cur_mode = MODE_OUTER;
        load_cfg();
        queue_lights(8'd200, 4);
        wait_idle();
        cur_mode = MODE_SPARE;
        load_cfg();
        queue_lights(8'd200, 3);
        wait_idle();

        // zero interval, a request every tick
        step_ivl[2] = '0;
        step_on     = 1'b1;
        cur_mode    = MODE_OUTER;
        load_cfg();
        queue_lights(8'd200, 6);
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            for (k = 0; k < 4; k++) begin
                if (p == 0) step_ivl[k] = '1;
                else if (p == 1) step_ivl[k] = '0;
                else if (p == 2) step_ivl[k] = IVL_W'(2550);
                else step_ivl[k] = pick_interval();
            end
            if (p < 8) cur_mode = MODE_W'(p);
            else cur_mode = MODE_W'($urandom_range(MODE_INNER, MODE_LEFT));
            // counter runs on while disabled, next phase re-enables it
            if (p == 3) step_on = 1'b0;
            else if (p == 4) step_on = 1'b1;
            else step_on = ($urandom_range(7) != 0);
            load_cfg();

            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            if (p == 9) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
                hold_arm       = 1'b1;
            end

            n_items = (cur_mode >= MODE_LEFT && cur_mode <= MODE_INNER) ? 117 : 30;
            for (k = 0; k < n_items; k++) light_q.push_back(pick_light());
            wait_idle();
        end

        $display("covered %0d light samples under %0d register settings, all pattern modes",
                 fed, cfg_loads);
        $display("took %0d pattern steps, compared %0d results", steps_taken, checked);
        if (err_cnt == 0 && expected_leds_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
